/* rtl/mqtt_publish_framer_unit_assert.svh */
// Assertion macros shared by the framer RTL files.
// Included by files that check their own logic; no other dependencies.
`ifndef MQTT_PUBLISH_FRAMER_UNIT_ASSERT_SVH
`define MQTT_PUBLISH_FRAMER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define MPF_ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("mpf check failed: condition must never hold");
`define MPF_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mpf check failed: implication violated");
`else
`define MPF_ASSERT_NEVER(name, clk, rst, cond)
`define MPF_ASSERT_IMPLIES(name, clk, rst, ante, cons)
`endif
`endif

/* rtl/mpf_pkg.sv */
// Types and constants of the MQTT PUBLISH framer.
// No dependencies; used by all framer modules.
package mpf_pkg;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_DATA,
      CMD_REJECT,
      CMD_NOOPEN
   } cmd_kind_type;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_DATA  = 1'b1;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_TOO_LONG   = 2'd1;
   localparam logic [1:0] ST_NO_PACKET  = 2'd2;

   localparam logic [7:0] HDR_PUBLISH = 8'h30;
   localparam logic [1:0] QOS_MASK    = 2'h3;
   localparam logic       VAR_MORE    = 1'b1;

   // One queued command: everything the back end needs to emit its bytes.
   typedef struct packed {
      cmd_kind_type kind;
      logic [1:0]   qos;
      logic [27:0]  rem;
      logic [2:0]   nrem;
      logic [15:0]  tlen;
      logic [7:0]   data;
      logic         with_pid;
      logic [15:0]  pid;
      logic         fin;
      logic [3:0]   cnt;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_flags_type;

endpackage

/* rtl/mpf_req_if.sv */
// Request channel of the framer: valid/ready plus start or data payload.
// Depends on nothing.
interface mpf_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [1:0]  qos;
   logic [15:0] topic_len;
   logic [27:0] body_len;
   logic [7:0]  data_byte;

   modport source (output valid, req_type, qos, topic_len, body_len, data_byte,
                   input ready);
   modport sink   (input valid, req_type, qos, topic_len, body_len, data_byte,
                   output ready);
endinterface

/* rtl/mpf_rsp_if.sv */
// Response channel of the framer: valid/ready plus one framed byte.
// Depends on nothing.
interface mpf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   logic [1:0] status;

   modport source (output valid, out_byte, last, status, input ready);
   modport sink   (input valid, out_byte, last, status, output ready);
endinterface

/* rtl/mpf_front.sv */
// Front end: accepts requests, tracks the open packet and builds commands.
// Depends on mpf_pkg, mpf_req_if and the assertion header.
`include "mqtt_publish_framer_unit_assert.svh"
module mpf_front (
   input  logic                clock,
   input  logic                reset,
   mpf_req_if.sink             req,
   input  mpf_pkg::q_flags_type q_flags,
   output logic                push,
   output mpf_pkg::cmd_type    cmd
);
   import mpf_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_TOPIC,
      PH_PAYLOAD
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] topic_left_ff, topic_left_in;
   logic [27:0] payload_left_ff, payload_left_in;
   logic [1:0]  held_qos_ff, held_qos_in;
   logic [15:0] packet_id_ff, packet_id_in;

   logic [28:0] rem_sum;
   logic [2:0]  rem_groups;

   assign req.ready = !q_flags.full;
   assign push      = req.valid && req.ready;

   always_comb begin
      rem_sum = 29'(req.topic_len) + 29'(req.body_len) + 29'd2
              + ((req.qos != 2'd0) ? 29'd2 : 29'd0);
      if (rem_sum[27:21] != 7'd0) begin
         rem_groups = 3'd4;
      end else if (rem_sum[20:14] != 7'd0) begin
         rem_groups = 3'd3;
      end else if (rem_sum[13:7] != 7'd0) begin
         rem_groups = 3'd2;
      end else begin
         rem_groups = 3'd1;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      topic_left_in   = topic_left_ff;
      payload_left_in = payload_left_ff;
      held_qos_in     = held_qos_ff;
      packet_id_in    = packet_id_ff;

      cmd.kind     = CMD_NOOPEN;
      cmd.qos      = req.qos & QOS_MASK;
      cmd.rem      = rem_sum[27:0];
      cmd.nrem     = rem_groups;
      cmd.tlen     = req.topic_len;
      cmd.data     = req.data_byte;
      cmd.with_pid = 1'b0;
      cmd.pid      = packet_id_ff;
      cmd.fin      = 1'b0;
      cmd.cnt      = 4'd1;

      if (push) begin
         if (req.req_type == REQ_START) begin
            // a new start abandons any open packet
            phase_in = PH_IDLE;
            if (rem_sum[28]) begin
               cmd.kind = CMD_REJECT;
            end else begin
               held_qos_in     = req.qos;
               topic_left_in   = req.topic_len;
               payload_left_in = req.body_len;
               cmd.kind        = CMD_START;
               cmd.with_pid    = (req.topic_len == 16'd0) && (req.qos != 2'd0);
               cmd.fin         = (req.topic_len == 16'd0) && (req.body_len == 28'd0);
               cmd.cnt         = 4'd3 + 4'(rem_groups) + (cmd.with_pid ? 4'd2 : 4'd0);
               if (cmd.with_pid) begin
                  packet_id_in = packet_id_ff + 16'd1;
               end
               if (req.topic_len != 16'd0) begin
                  phase_in = PH_TOPIC;
               end else if (req.body_len != 28'd0) begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end else begin
            case (phase_ff)
               PH_TOPIC: begin
                  cmd.kind      = CMD_DATA;
                  topic_left_in = topic_left_ff - 16'd1;
                  if (topic_left_ff == 16'd1) begin
                     cmd.with_pid = (held_qos_ff != 2'd0);
                     cmd.fin      = (payload_left_ff == 28'd0);
                     cmd.cnt      = cmd.with_pid ? 4'd3 : 4'd1;
                     if (cmd.with_pid) begin
                        packet_id_in = packet_id_ff + 16'd1;
                     end
                     phase_in = cmd.fin ? PH_IDLE : PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  cmd.kind        = CMD_DATA;
                  payload_left_in = payload_left_ff - 28'd1;
                  if (payload_left_ff == 28'd1) begin
                     cmd.fin  = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  cmd.kind = CMD_NOOPEN;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         topic_left_ff   <= '0;
         payload_left_ff <= '0;
         held_qos_ff     <= '0;
         packet_id_ff    <= 16'd1;
      end else begin
         phase_ff        <= phase_in;
         topic_left_ff   <= topic_left_in;
         payload_left_ff <= payload_left_in;
         held_qos_ff     <= held_qos_in;
         packet_id_ff    <= packet_id_in;
      end
   end

   `MPF_ASSERT_IMPLIES(a_topic_left_live, clock, reset, phase_ff == PH_TOPIC, topic_left_ff != 16'd0)
   `MPF_ASSERT_IMPLIES(a_payload_left_live, clock, reset, phase_ff == PH_PAYLOAD, payload_left_ff != 28'd0)

endmodule

/* rtl/mpf_cmd_fifo.sv */
// Short command queue between the front and back ends.
// Depends on mpf_pkg and the assertion header.
`include "mqtt_publish_framer_unit_assert.svh"
module mpf_cmd_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mpf_pkg::cmd_type     push_cmd,
   input  logic                 pop,
   output mpf_pkg::cmd_type     head,
   output mpf_pkg::q_flags_type q_flags
);
   import mpf_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type       entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign head          = entry_ff[rd_ptr_ff];
   assign q_flags.full  = (count_ff == CW'(DEPTH));
   assign q_flags.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `MPF_ASSERT_NEVER(a_no_push_full, clock, reset, push && q_flags.full && !pop)
   `MPF_ASSERT_NEVER(a_no_pop_empty, clock, reset, pop && q_flags.empty)

endmodule

/* rtl/mpf_back.sv */
// Back end: expands queued commands into framed bytes, one per cycle while rsp is ready.
// Depends on mpf_pkg, mpf_rsp_if and the assertion header.
`include "mqtt_publish_framer_unit_assert.svh"
module mpf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  mpf_pkg::cmd_type     head,
   input  mpf_pkg::q_flags_type q_flags,
   output logic                 pop,
   mpf_rsp_if.source            rsp
);
   import mpf_pkg::*;

   cmd_type    cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [3:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       last_ff, last_in;
   logic [1:0] status_ff, status_in;

   logic       advance;
   logic       final_step;
   logic [3:0] nrem_ext;
   logic [6:0] group_bits;
   logic [7:0] sel_byte;
   logic [1:0] sel_status;

   assign advance    = cur_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign final_step = (step_ff == cur_ff.cnt - 4'd1);
   assign pop        = !q_flags.empty && (!cur_valid_ff || (advance && final_step));
   assign nrem_ext   = {1'b0, cur_ff.nrem};

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_byte = out_byte_ff;
   assign rsp.last     = last_ff;
   assign rsp.status   = status_ff;

   // pick the 7-bit group of the remaining length for this step
   always_comb begin
      case (step_ff[1:0])
         2'd1:    group_bits = cur_ff.rem[6:0];
         2'd2:    group_bits = cur_ff.rem[13:7];
         2'd3:    group_bits = cur_ff.rem[20:14];
         default: group_bits = cur_ff.rem[27:21];
      endcase
   end

   always_comb begin
      sel_byte   = 8'h00;
      sel_status = ST_OK;
      case (cur_ff.kind)
         CMD_START: begin
            if (step_ff == 4'd0) begin
               sel_byte = HDR_PUBLISH | {5'd0, cur_ff.qos, 1'b0};
            end else if (step_ff <= nrem_ext) begin
               sel_byte = {(step_ff < nrem_ext) ? VAR_MORE : 1'b0, group_bits};
            end else if (step_ff == nrem_ext + 4'd1) begin
               sel_byte = cur_ff.tlen[15:8];
            end else if (step_ff == nrem_ext + 4'd2) begin
               sel_byte = cur_ff.tlen[7:0];
            end else if (step_ff == nrem_ext + 4'd3) begin
               sel_byte = cur_ff.pid[15:8];
            end else begin
               sel_byte = cur_ff.pid[7:0];
            end
         end
         CMD_DATA: begin
            if (step_ff == 4'd0) begin
               sel_byte = cur_ff.data;
            end else if (step_ff == 4'd1) begin
               sel_byte = cur_ff.pid[15:8];
            end else begin
               sel_byte = cur_ff.pid[7:0];
            end
         end
         CMD_REJECT: begin
            sel_status = ST_TOO_LONG;
         end
         default: begin
            sel_status = ST_NO_PACKET;
         end
      endcase
   end

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      out_byte_in  = out_byte_ff;
      last_in      = last_ff;
      status_in    = status_ff;

      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         out_byte_in  = sel_byte;
         last_in      = cur_ff.fin && final_step;
         status_in    = sel_status;
         if (final_step) begin
            step_in      = 4'd0;
            cur_valid_in = pop;
         end else begin
            step_in = step_ff + 4'd1;
         end
      end else if (!cur_valid_ff) begin
         step_in      = 4'd0;
         cur_valid_in = pop;
      end
      if (pop) begin
         cur_in = head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      last_ff     <= last_in;
      status_ff   <= status_in;
   end

   `MPF_ASSERT_NEVER(a_step_in_range, clock, reset, cur_valid_ff && (step_ff >= cur_ff.cnt))
   `MPF_ASSERT_IMPLIES(a_status_not_last, clock, reset, rsp_valid_ff && (status_ff != ST_OK), !last_ff)

endmodule

/* rtl/mqtt_publish_framer_unit.sv */
// MQTT PUBLISH framer: request channel in, framed byte stream out.
// A start request (req_type 0) carries qos, topic_len and body_len; the
// block answers with the fixed header, 1 to 4 remaining-length bytes and the
// two topic-length bytes (plus the packet identifier when the topic is empty
// and qos is nonzero). Data requests (req_type 1) pass one topic or payload
// byte; the last topic byte is followed by the packet identifier when qos is
// nonzero. The final byte of a packet has last set. A too-long start gives
// one byte with status 1; a data byte with no open packet gives status 2.
// An accepted request passes through the command queue and the back end's
// current-command register before its bytes are registered onto rsp.
// Throughput: one byte per cycle on rsp while rsp is ready and commands are
// queued; data requests are accepted one per cycle while the queue is not
// full, and the command queue (QUEUE_DEPTH entries) absorbs further requests
// while the back end emits the bytes of earlier commands.
// Reset clears the open packet, the queue and the output valid flag, and sets
// the packet identifier to 1. When rsp stalls, the output byte holds, the
// queue fills, and req_chan.ready drops once the queue is full.
module mqtt_publish_framer_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input logic        clock,
   input logic        reset,
   mpf_req_if.sink    req_chan,
   mpf_rsp_if.source  rsp_chan
);
   import mpf_pkg::*;

   logic        push;
   logic        pop;
   cmd_type     push_cmd;
   cmd_type     head;
   q_flags_type q_flags;

   mpf_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .q_flags (q_flags),
      .push    (push),
      .cmd     (push_cmd)
   );

   mpf_cmd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .q_flags  (q_flags)
   );

   mpf_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .q_flags (q_flags),
      .pop     (pop),
      .rsp     (rsp_chan)
   );

endmodule
